// File: sv/cmc_pkg.sv
// Shared types, codes and constants of the car command motor controller.
// No dependencies; every other file of the block but cmc_if takes its names from here.
`default_nettype none

package cmc_pkg;

    // Default duty ceiling of the bridge outputs.
    localparam int DUTY_MAX_DEF = 1023;

    // Width of the signed differential mix sum before division by 1000.
    localparam int SUM_W = 34;

    // Item operations.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    // Packet kinds.
    localparam logic [2:0] PK_DRIVE     = 3'd1;
    localparam logic [2:0] PK_HEARTBEAT = 3'd2;
    localparam logic [2:0] PK_SPEED     = 3'd3;
    localparam logic [2:0] PK_CALIB     = 3'd4;
    localparam logic [2:0] PK_SERVO     = 3'd5;

    // Drive command codes.
    localparam logic signed [15:0] DC_STOP   = 16'sd0;
    localparam logic signed [15:0] DC_FWD    = 16'sd1;
    localparam logic signed [15:0] DC_BACK   = 16'sd2;
    localparam logic signed [15:0] DC_TURN_L = 16'sd3;
    localparam logic signed [15:0] DC_TURN_R = 16'sd4;
    localparam logic signed [15:0] DC_CENTER = 16'sd5;
    localparam logic signed [15:0] DC_STEER  = 16'sd6;

    // Servo test subcommand that sets an angle.
    localparam logic signed [15:0] SV_SET_ANGLE = 16'sd1;

    // Reply kinds.
    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_VOLT = 2'd1;
    localparam logic [1:0] RK_CAL  = 2'd2;

    // Drive modes.
    localparam logic [1:0] DM_STOPPED = 2'd0;
    localparam logic [1:0] DM_FWD     = 2'd1;
    localparam logic [1:0] DM_BACK    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SERVO   = 3'd0;
    localparam logic [2:0] CFG_GAIN    = 3'd1;
    localparam logic [2:0] CFG_CENTER  = 3'd2;
    localparam logic [2:0] CFG_LSPAN   = 3'd3;
    localparam logic [2:0] CFG_RSPAN   = 3'd4;
    localparam logic [2:0] CFG_WDLIM   = 3'd5;
    localparam logic [2:0] CFG_SWAP_L  = 3'd6;
    localparam logic [2:0] CFG_SWAP_R  = 3'd7;

    // Steer gain factor applied to the differential swing.
    typedef enum logic [1:0] {
        K_POS10,
        K_POS13,
        K_NEG10
    } k_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MIX,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    // One input beat.
    typedef struct packed {
        logic               operation;
        logic [2:0]         packet_kind;
        logic signed [15:0] arg_first;
        logic signed [15:0] arg_second;
        logic [9:0]         battery_sample;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [9:0]         duty_left_a;
        logic [9:0]         duty_left_b;
        logic [9:0]         duty_right_a;
        logic [9:0]         duty_right_b;
        logic [7:0]         servo_angle;
        logic               servo_update;
        logic [1:0]         reply_kind;
        logic signed [15:0] reply_value;
        logic               link_lost;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic mix;
        logic div_start;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/cmc_if.sv
// Stream interfaces for the input items and the result beats.
// Depends on nothing; payload fields carry the widths of the block's ports.
`default_nettype none

interface cmc_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [2:0]         packet_kind;
    logic signed [15:0] arg_first;
    logic signed [15:0] arg_second;
    logic [9:0]         battery_sample;

    modport source (
        output valid, operation, packet_kind, arg_first, arg_second, battery_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, packet_kind, arg_first, arg_second, battery_sample,
        output ready
    );
endinterface

interface cmc_result_if;
    logic               valid;
    logic               ready;
    logic [9:0]         duty_left_a;
    logic [9:0]         duty_left_b;
    logic [9:0]         duty_right_a;
    logic [9:0]         duty_right_b;
    logic [7:0]         servo_angle;
    logic               servo_update;
    logic [1:0]         reply_kind;
    logic signed [15:0] reply_value;
    logic               link_lost;

    modport source (
        output valid, duty_left_a, duty_left_b, duty_right_a, duty_right_b,
               servo_angle, servo_update, reply_kind, reply_value, link_lost,
        input  ready
    );
    modport sink (
        input  valid, duty_left_a, duty_left_b, duty_right_a, duty_right_b,
               servo_angle, servo_update, reply_kind, reply_value, link_lost,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/cmc_div.sv
// Divide-by-1000 lane with saturation for one differential mix sum.
// Depends on cmc_pkg for SUM_W; a shift by 3 and a reciprocal multiply by 1/125.
`default_nettype none

module cmc_div #(
    parameter int DUTY_MAX = cmc_pkg::DUTY_MAX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                start,
    input  wire logic                                step,
    input  wire logic signed [cmc_pkg::SUM_W-1:0]    sum,
    output logic [$clog2(DUTY_MAX+1)-1:0]            q,
    output logic                                     neg
);

    localparam int DUTY_W = $clog2(DUTY_MAX + 1);
    // Below saturation the magnitude is under 65536 * 1000, so 23 bits remain
    // after dropping the three low bits.
    localparam int X_W    = 23;
    localparam int RCP_W  = 24;
    localparam int RCP_SH = 30;
    // Rounded-up 2^30 / 125; exact for every 23 bit dividend.
    localparam logic [RCP_W-1:0] RCP_125 = 24'd8589935;
    localparam logic [cmc_pkg::SUM_W-1:0] SAT_LIM =
        cmc_pkg::SUM_W'((DUTY_MAX + 1) * 1000);

    logic [cmc_pkg::SUM_W-1:0] mag;
    logic [X_W-1:0]            x_reg;
    logic [X_W+RCP_W-1:0]      prod_reg;
    logic                      sat_reg;
    logic                      neg_reg;

    // Magnitude of the signed sum; division truncates toward zero.
    assign mag = sum[cmc_pkg::SUM_W-1] ? cmc_pkg::SUM_W'(-sum) : cmc_pkg::SUM_W'(sum);

    // First step takes the magnitude over 8, second multiplies by 1/125.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= mag[X_W+2:3];
            sat_reg <= (mag >= SAT_LIM);
            neg_reg <= sum[cmc_pkg::SUM_W-1];
        end
        else if (step)
        begin
            prod_reg <= x_reg * RCP_125;
        end
    end

    assign q   = sat_reg ? DUTY_W'(DUTY_MAX) : prod_reg[RCP_SH+DUTY_W-1:RCP_SH];
    assign neg = neg_reg;

endmodule

`default_nettype wire

// File: sv/cmc_ctrl.sv
// Controller state machine: sequences load, multiply, mix, divide and commit.
// Depends on cmc_pkg for the state type and the command and status structs.
`default_nettype none

module cmc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cmc_pkg::dp_stat_t stat,
    output cmc_pkg::dp_cmd_t       cmd
);

    cmc_pkg::state_t  state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    // The result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cmc_pkg::ST_MUL;
                end
            end
            cmc_pkg::ST_MUL:
            begin
                state_next = cmc_pkg::ST_MIX;
            end
            cmc_pkg::ST_MIX:
            begin
                state_next = stat.need_div ? cmc_pkg::ST_LOAD : cmc_pkg::ST_FINISH;
            end
            cmc_pkg::ST_LOAD:
            begin
                state_next = cmc_pkg::ST_DIV;
            end
            cmc_pkg::ST_DIV:
            begin
                state_next = cmc_pkg::ST_FINISH;
            end
            cmc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            cmc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cmc_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            cmc_pkg::ST_MIX:
            begin
                cmd.mix = 1'b1;
            end
            cmc_pkg::ST_LOAD:
            begin
                cmd.div_start = 1'b1;
            end
            cmc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            cmc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/cmc_dp.sv
// Datapath: configuration, drive state, mix and servo arithmetic, result register.
// Depends on cmc_pkg and on cmc_div for the two divide-by-1000 lanes.
`default_nettype none

module cmc_dp #(
    parameter int DUTY_MAX = cmc_pkg::DUTY_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [2:0]        wr_index,
    input  wire logic [15:0]       wr_data,
    input  wire cmc_pkg::item_t    item,
    input  wire cmc_pkg::dp_cmd_t  cmd,
    output cmc_pkg::dp_stat_t      stat,
    output cmc_pkg::result_t       res
);

    localparam int DUTY_W = $clog2(DUTY_MAX + 1);
    localparam int SW     = cmc_pkg::SUM_W;

    // Configuration registers.
    logic               servo_reg;
    logic [9:0]         gain_reg;
    logic [7:0]         center_reg;
    logic signed [7:0]  lspan_reg;
    logic signed [7:0]  rspan_reg;
    logic [15:0]        wdlim_reg;
    logic               swap_l_reg;
    logic               swap_r_reg;

    // Drive state.
    logic [1:0]         mode_reg, mode_next;
    logic signed [15:0] steer_reg, steer_next;
    logic signed [15:0] engine_reg, engine_next;
    logic signed [15:0] turn_reg, turn_next;
    logic signed [15:0] offset_reg, offset_next;
    logic [15:0]        wd_reg, wd_next;
    logic [DUTY_W-1:0]  duty_reg [4];
    logic [DUTY_W-1:0]  duty_next [4];
    logic [7:0]         angle_reg, angle_next;

    // Item and intermediate registers.
    cmc_pkg::item_t     item_reg;
    logic signed [28:0] dg_reg;
    logic signed [16:0] spd_reg;
    cmc_pkg::k_sel_t    ksel_reg;
    logic [14:0]        mv_reg;
    logic signed [15:0] num_reg;
    logic signed [SW-1:0] sum_l_reg;
    logic signed [SW-1:0] sum_r_reg;
    logic [9:0]         ang_q_reg;
    logic               ang_neg_reg;
    cmc_pkg::result_t   res_reg, res_next;

    // Decode of the held item.
    logic               is_packet;
    logic               is_drive;
    logic signed [15:0] code;
    logic signed [15:0] arg;
    logic signed [15:0] mix_steer;
    logic signed [17:0] d;
    logic signed [10:0] gain_s;
    logic signed [28:0] dg_next;
    logic signed [16:0] es17;
    logic signed [16:0] spd_next;
    cmc_pkg::k_sel_t    ksel_next;
    logic [24:0]        mv_prod;
    logic               arg_low;
    logic [5:0]         amul;
    logic signed [6:0]  amul_s;
    logic signed [7:0]  span;
    logic signed [14:0] aprod;
    logic [13:0]        c50;
    logic signed [15:0] num_next;
    logic signed [SW-1:0] dg_w;
    logic signed [SW-1:0] sw_w;
    logic signed [SW-1:0] t_mix;
    logic signed [SW-1:0] s1000;
    logic [29:0]        ang_prod;
    logic [DUTY_W-1:0]  q_l, q_r;
    logic               neg_l, neg_r;
    logic               steer_in_range;
    logic               angle_in_range;
    logic [7:0]         ang_clamped;
    logic signed [17:0] volt_sum;
    logic signed [17:0] cal_diff;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [15:0] v);
        logic [DUTY_W-1:0] r;
        if (v[15])
        begin
            r = '0;
        end
        else if (32'(v[14:0]) > 32'(DUTY_MAX))
        begin
            r = DUTY_W'(DUTY_MAX);
        end
        else
        begin
            r = DUTY_W'(v[14:0]);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_reg  <= 1'b0;
            gain_reg   <= 10'd256;
            center_reg <= 8'd97;
            lspan_reg  <= 8'sd25;
            rspan_reg  <= -8'sd25;
            wdlim_reg  <= 16'd2500;
            swap_l_reg <= 1'b1;
            swap_r_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cmc_pkg::CFG_SERVO:  servo_reg  <= wr_data[0];
                cmc_pkg::CFG_GAIN:   gain_reg   <= wr_data[9:0];
                cmc_pkg::CFG_CENTER: center_reg <= wr_data[7:0];
                cmc_pkg::CFG_LSPAN:  lspan_reg  <= wr_data[7:0];
                cmc_pkg::CFG_RSPAN:  rspan_reg  <= wr_data[7:0];
                cmc_pkg::CFG_WDLIM:  wdlim_reg  <= wr_data;
                cmc_pkg::CFG_SWAP_L: swap_l_reg <= wr_data[0];
                cmc_pkg::CFG_SWAP_R: swap_r_reg <= wr_data[0];
            endcase
        end
    end

    // Item decode.
    assign is_packet = (item_reg.operation == cmc_pkg::OP_PACKET);
    assign is_drive  = is_packet && (item_reg.packet_kind == cmc_pkg::PK_DRIVE);
    assign code      = item_reg.arg_first;
    assign arg       = item_reg.arg_second;

    // A mix is needed for forward, back and steer on a differential chassis.
    assign stat.need_div = is_drive && !servo_reg &&
        ((code == cmc_pkg::DC_FWD) || (code == cmc_pkg::DC_BACK) ||
         ((code == cmc_pkg::DC_STEER) &&
          ((mode_reg == cmc_pkg::DM_STOPPED) || (mode_reg == cmc_pkg::DM_FWD) ||
           (mode_reg == cmc_pkg::DM_BACK))));

    // First stage: steer swing times gain, speed and factor selection.
    assign mix_steer = (code == cmc_pkg::DC_STEER) ? arg : steer_reg;
    assign d         = {{1{mix_steer[15]}}, mix_steer, 1'b0} - 18'sd100;
    assign gain_s    = $signed({1'b0, gain_reg});
    assign dg_next   = d * gain_s;
    assign es17      = {engine_reg[15], engine_reg};

    always_comb
    begin
        priority if (code == cmc_pkg::DC_FWD)
        begin
            spd_next  = es17;
            ksel_next = cmc_pkg::K_POS10;
        end
        else if (code == cmc_pkg::DC_BACK)
        begin
            spd_next  = -es17;
            ksel_next = cmc_pkg::K_POS10;
        end
        else if (mode_reg == cmc_pkg::DM_STOPPED)
        begin
            spd_next  = '0;
            ksel_next = cmc_pkg::K_POS13;
        end
        else if (mode_reg == cmc_pkg::DM_FWD)
        begin
            spd_next  = es17;
            ksel_next = cmc_pkg::K_POS10;
        end
        else
        begin
            spd_next  = -es17;
            ksel_next = cmc_pkg::K_NEG10;
        end
    end

    // Battery millivolts: sample * 16500 / 1024.
    assign mv_prod = item_reg.battery_sample * 15'd16500;

    // Servo angle numerator: distance of the steer value from 50 times span, plus center * 50.
    assign arg_low  = (arg < 16'sd50);
    assign amul     = arg_low ? 6'(16'sd50 - arg) : 6'(arg - 16'sd50);
    assign amul_s   = $signed({1'b0, amul});
    assign span     = arg_low ? lspan_reg : rspan_reg;
    assign aprod    = amul_s * span;
    assign c50      = center_reg * 6'd50;
    assign num_next = 16'(aprod) + $signed({2'b00, c50});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.mul)
        begin
            dg_reg   <= dg_next;
            spd_reg  <= spd_next;
            ksel_reg <= ksel_next;
            mv_reg   <= mv_prod[24:10];
            num_reg  <= num_next;
        end
    end

    // Second stage: apply the steer factor and form both motor sums.
    assign dg_w  = SW'(dg_reg);
    assign sw_w  = SW'(spd_reg);
    assign s1000 = (sw_w <<< 10) - (sw_w <<< 5) + (sw_w <<< 3);

    always_comb
    begin
        unique case (ksel_reg)
            cmc_pkg::K_POS10: t_mix = (dg_w <<< 3) + (dg_w <<< 1);
            cmc_pkg::K_POS13: t_mix = (dg_w <<< 3) + (dg_w <<< 2) + dg_w;
            cmc_pkg::K_NEG10: t_mix = -((dg_w <<< 3) + (dg_w <<< 1));
            default:          t_mix = '0;
        endcase
    end

    // Divide the angle numerator by 50 through a scaled reciprocal.
    assign ang_prod = num_reg[14:0] * 15'd20972;

    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            sum_l_reg   <= s1000 + t_mix;
            sum_r_reg   <= s1000 - t_mix;
            ang_q_reg   <= ang_prod[29:20];
            ang_neg_reg <= num_reg[15];
        end
    end

    // Divide-by-1000 lanes for the left and right motors.
    cmc_div #(
        .DUTY_MAX (DUTY_MAX)
    ) u_div_l (
        .clk   (clk),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .sum   (sum_l_reg),
        .q     (q_l),
        .neg   (neg_l)
    );

    cmc_div #(
        .DUTY_MAX (DUTY_MAX)
    ) u_div_r (
        .clk   (clk),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .sum   (sum_r_reg),
        .q     (q_r),
        .neg   (neg_r)
    );

    // Range checks and saturation of replies.
    assign steer_in_range = !arg[15] && (arg <= 16'sd100);
    assign angle_in_range = !arg[15] && (arg <= 16'sd180);
    assign ang_clamped    = ang_neg_reg ? 8'd0 :
                            ((ang_q_reg > 10'd180) ? 8'd180 : ang_q_reg[7:0]);
    assign volt_sum       = $signed({3'b000, mv_reg}) + 18'(offset_reg);
    assign cal_diff       = 18'(item_reg.arg_first) - $signed({3'b000, mv_reg});

    // Next drive state and result of the held item.
    always_comb
    begin
        mode_next   = mode_reg;
        steer_next  = steer_reg;
        engine_next = engine_reg;
        turn_next   = turn_reg;
        offset_next = offset_reg;
        wd_next     = wd_reg;
        angle_next  = angle_reg;
        for (int i = 0; i < 4; i++)
        begin
            duty_next[i] = duty_reg[i];
        end
        res_next              = '0;
        res_next.reply_kind   = cmc_pkg::RK_NONE;

        if (!is_packet)
        begin
            // Watchdog tick.
            if (wd_reg >= wdlim_reg)
            begin
                res_next.link_lost = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    duty_next[i] = '0;
                end
                mode_next  = cmc_pkg::DM_STOPPED;
                steer_next = 16'sd50;
                wd_next    = '0;
            end
            else
            begin
                wd_next = wd_reg + 16'd1;
            end
        end
        else
        begin
            unique case (item_reg.packet_kind)
                cmc_pkg::PK_DRIVE:
                begin
                    if (code == cmc_pkg::DC_STOP)
                    begin
                        mode_next    = cmc_pkg::DM_STOPPED;
                        duty_next[0] = '0;
                        duty_next[1] = '0;
                        if (!servo_reg)
                        begin
                            duty_next[2] = '0;
                            duty_next[3] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_FWD)
                    begin
                        mode_next = cmc_pkg::DM_FWD;
                        if (servo_reg)
                        begin
                            duty_next[0] = sat_duty(engine_reg);
                            duty_next[1] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_BACK)
                    begin
                        mode_next = cmc_pkg::DM_BACK;
                        if (servo_reg)
                        begin
                            duty_next[1] = sat_duty(engine_reg);
                            duty_next[0] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_TURN_L)
                    begin
                        if (servo_reg)
                        begin
                            duty_next[2] = sat_duty(turn_reg);
                            duty_next[3] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_TURN_R)
                    begin
                        if (servo_reg)
                        begin
                            duty_next[3] = sat_duty(turn_reg);
                            duty_next[2] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_CENTER)
                    begin
                        if (servo_reg)
                        begin
                            duty_next[2] = '0;
                            duty_next[3] = '0;
                        end
                    end
                    else if (code == cmc_pkg::DC_STEER)
                    begin
                        if (servo_reg)
                        begin
                            if (steer_in_range)
                            begin
                                angle_next            = ang_clamped;
                                res_next.servo_update = 1'b1;
                            end
                        end
                        else
                        begin
                            steer_next = arg;
                        end
                    end

                    // Differential mix results: a negative value drives pin B.
                    if (stat.need_div)
                    begin
                        duty_next[0] = neg_l ? '0 : q_l;
                        duty_next[1] = neg_l ? q_l : '0;
                        duty_next[2] = neg_r ? '0 : q_r;
                        duty_next[3] = neg_r ? q_r : '0;
                    end
                end
                cmc_pkg::PK_HEARTBEAT:
                begin
                    wd_next              = '0;
                    res_next.reply_kind  = cmc_pkg::RK_VOLT;
                    res_next.reply_value = sat16(volt_sum);
                end
                cmc_pkg::PK_SPEED:
                begin
                    engine_next = item_reg.arg_first;
                    turn_next   = arg;
                end
                cmc_pkg::PK_CALIB:
                begin
                    offset_next         = sat16(cal_diff);
                    res_next.reply_kind = cmc_pkg::RK_CAL;
                end
                cmc_pkg::PK_SERVO:
                begin
                    if ((item_reg.arg_first == cmc_pkg::SV_SET_ANGLE) && angle_in_range)
                    begin
                        angle_next            = arg[7:0];
                        res_next.servo_update = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        // Physical outputs after the pin swap.
        res_next.duty_left_a  = swap_l_reg ? 10'(duty_next[1]) : 10'(duty_next[0]);
        res_next.duty_left_b  = swap_l_reg ? 10'(duty_next[0]) : 10'(duty_next[1]);
        res_next.duty_right_a = swap_r_reg ? 10'(duty_next[3]) : 10'(duty_next[2]);
        res_next.duty_right_b = swap_r_reg ? 10'(duty_next[2]) : 10'(duty_next[3]);
        res_next.servo_angle  = angle_next;
    end

    // Drive state update at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cmc_pkg::DM_STOPPED;
            steer_reg  <= 16'sd50;
            engine_reg <= 16'sd500;
            turn_reg   <= 16'sd750;
            offset_reg <= '0;
            wd_reg     <= '0;
            angle_reg  <= 8'd97;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            mode_reg   <= mode_next;
            steer_reg  <= steer_next;
            engine_reg <= engine_next;
            turn_reg   <= turn_next;
            offset_reg <= offset_next;
            wd_reg     <= wd_next;
            angle_reg  <= angle_next;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: sv/car_command_motor_controller.sv
// Car command motor controller: takes ticks and command packets and returns
// one result beat per input beat with the bridge duties, servo angle and replies.
//
// Channels: items (sink) carries one tick or decoded packet per beat; results
// (source) carries one beat per item. A beat moves when valid and ready are high.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write it only while idle, which the block itself does not enforce.
//
// An item taken in the idle state passes the multiply and mix states, and its
// result is registered in the finish state; on a differential chassis forward,
// back and steer also pass the load and divide states to divide both motor sums
// by 1000. The next item is taken in the cycle after the result is registered.
//
// Stall: the result stays in its output register while the receiver holds ready
// low; the next item is still taken and worked on, and waits at its final step
// until the output register is free.
//
// Reset (rst_n low, asynchronous) loads the register defaults, stops the
// motors, sets steer 50 and the servo angle 97, and empties the output.
`default_nettype none

module car_command_motor_controller #(
    parameter int DUTY_MAX = cmc_pkg::DUTY_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cmc_item_if.sink         items,
    cmc_result_if.source     results,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    cmc_pkg::item_t    item;
    cmc_pkg::result_t  res;
    cmc_pkg::dp_cmd_t  cmd;
    cmc_pkg::dp_stat_t stat;

    // Gather the input beat.
    assign item.operation      = items.operation;
    assign item.packet_kind    = items.packet_kind;
    assign item.arg_first      = items.arg_first;
    assign item.arg_second     = items.arg_second;
    assign item.battery_sample = items.battery_sample;

    cmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cmc_dp #(
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item),
        .cmd      (cmd),
        .stat     (stat),
        .res      (res)
    );

    // Drive the result beat.
    assign results.duty_left_a  = res.duty_left_a;
    assign results.duty_left_b  = res.duty_left_b;
    assign results.duty_right_a = res.duty_right_a;
    assign results.duty_right_b = res.duty_right_b;
    assign results.servo_angle  = res.servo_angle;
    assign results.servo_update = res.servo_update;
    assign results.reply_kind   = res.reply_kind;
    assign results.reply_value  = res.reply_value;
    assign results.link_lost    = res.link_lost;

endmodule

`default_nettype wire
